>>> rtl/pdd_pkg.sv
package pdd_pkg;

    localparam int BYTE_W = 8;
    localparam int RGB_W  = 24;
    localparam int LEN_W  = 10;
    localparam int CNT_W  = 7;
    localparam int SRC_W  = 9;
    localparam int SUM_W  = 10;

    localparam logic [BYTE_W-1:0] SKIP_FLAG = 8'h80;
    localparam logic [BYTE_W-1:0] SKIP_MASK = 8'h7F;
    localparam logic [BYTE_W-1:0] COPY_FLAG = 8'h40;
    localparam logic [BYTE_W-1:0] VAL_MASK  = 8'h3F;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_SNAP    = 6'b000100,
        ST_COPY_RD = 6'b001000,
        ST_COPY_WR = 6'b010000,
        ST_LIT     = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        PH_CMD   = 4'b0001,
        PH_SRC   = 4'b0010,
        PH_GREEN = 4'b0100,
        PH_BLUE  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic push;
        logic last;
    } emit_t;

    typedef struct packed {
        logic cur_we;
        logic cur_re;
        logic snap_we;
        logic snap_re;
    } ram_ctl_t;

    // 6-bit level to 8 bits: (v << 2) | (v >> 4)
    function automatic logic [BYTE_W-1:0] expand6(input logic [BYTE_W-1:0] v);
        logic [5:0] s;
        s = v[5:0];
        return {s, s[5:4]};
    endfunction

endpackage

>>> rtl/pdd_ram.sv
module pdd_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 24
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pdd_ctrl.sv
module pdd_ctrl import pdd_pkg::*; #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int IDX_W           = 8,
    parameter int POS_W           = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              chunk_valid,
    input  logic [BYTE_W-1:0] chunk_byte,
    output logic              chunk_stall,
    input  logic              push_ok,
    output emit_t             emit,
    output logic [BYTE_W-1:0] emit_index,
    output logic [RGB_W-1:0]  emit_rgb,
    output ram_ctl_t          ram_ctl,
    output logic [IDX_W-1:0]  cur_waddr,
    output logic [RGB_W-1:0]  cur_wdata,
    output logic [IDX_W-1:0]  cur_raddr,
    input  logic [RGB_W-1:0]  cur_rdata,
    output logic [IDX_W-1:0]  snap_waddr,
    output logic [RGB_W-1:0]  snap_wdata,
    output logic [IDX_W-1:0]  snap_raddr,
    input  logic [RGB_W-1:0]  snap_rdata
);

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [IDX_W:0]     sweep_reg, sweep_next;
    logic               sw_wr_reg, sw_wr_next;
    logic [IDX_W-1:0]   sw_addr_reg, sw_addr_next;
    logic [BYTE_W-1:0]  cmd_reg, cmd_next;
    logic [BYTE_W-1:0]  green_reg, green_next;
    logic [BYTE_W-1:0]  blue_reg, blue_next;

    logic [SUM_W-1:0]   add_b;
    logic [SUM_W-1:0]   sum;
    logic [POS_W-1:0]   pos_sat;
    logic               pos_in;
    logic               src_in;
    logic               accept;
    logic [LEN_W-1:0]   bytes_dec;
    logic [RGB_W-1:0]   lit_rgb;

    assign accept      = chunk_valid && (state_reg == ST_IDLE);
    assign chunk_stall = (state_reg != ST_IDLE);
    assign pos_in      = pos_reg < POS_W'(PALETTE_ENTRIES);
    assign src_in      = src_reg < SRC_W'(PALETTE_ENTRIES);
    assign bytes_dec   = bytes_left_reg - LEN_W'(1);
    assign lit_rgb     = {expand6(cmd_reg), expand6(green_reg), expand6(blue_reg)};

    // shared position adder with saturation
    always_comb
    begin
        case (state_reg)
            ST_IDLE:    add_b = SUM_W'(chunk_byte & SKIP_MASK) + SUM_W'(1);
            ST_COPY_RD: add_b = SUM_W'(cnt_reg);
            default:    add_b = SUM_W'(1);
        endcase
        sum     = SUM_W'(pos_reg) + add_b;
        pos_sat = (sum > SUM_W'(PALETTE_ENTRIES)) ? POS_W'(PALETTE_ENTRIES)
                                                  : sum[POS_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        src_next        = src_reg;
        sweep_next      = sweep_reg;
        sw_wr_next      = 1'b0;
        sw_addr_next    = sw_addr_reg;
        cmd_next        = cmd_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;

        ram_ctl         = '0;
        emit            = '0;
        emit_index      = BYTE_W'(pos_reg);
        emit_rgb        = snap_rdata;
        cur_waddr       = pos_reg[IDX_W-1:0];
        cur_wdata       = snap_rdata;
        cur_raddr       = sweep_reg[IDX_W-1:0];
        snap_waddr      = sw_addr_reg;
        snap_wdata      = cur_rdata;
        snap_raddr      = src_reg[IDX_W-1:0];

        ram_ctl.snap_we = sw_wr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_ctl.cur_we  = 1'b1;
                ram_ctl.snap_we = 1'b1;
                cur_waddr       = sweep_reg[IDX_W-1:0];
                snap_waddr      = sweep_reg[IDX_W-1:0];
                cur_wdata       = '0;
                snap_wdata      = '0;
                if (sweep_reg == (IDX_W+1)'(PALETTE_ENTRIES - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + (IDX_W+1)'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    if (bytes_left_reg == '0)
                    begin
                        bytes_left_next = (chunk_byte == '0) ? '0
                                        : {chunk_byte, 2'b00} - LEN_W'(1);
                        pos_next   = '0;
                        phase_next = PH_CMD;
                        sweep_next = '0;
                        state_next = ST_SNAP;
                    end
                    else
                    begin
                        bytes_left_next = bytes_dec;
                        case (phase_reg)
                            PH_CMD:
                            begin
                                if ((chunk_byte & SKIP_FLAG) != '0)
                                begin
                                    pos_next = pos_sat;
                                end
                                else
                                begin
                                    cmd_next   = chunk_byte;
                                    phase_next = ((chunk_byte & COPY_FLAG) != '0)
                                               ? PH_SRC : PH_GREEN;
                                end
                            end
                            PH_SRC:
                            begin
                                cnt_next   = CNT_W'(cmd_reg & VAL_MASK) + CNT_W'(1);
                                src_next   = SRC_W'(chunk_byte);
                                phase_next = PH_CMD;
                                state_next = ST_COPY_RD;
                            end
                            PH_GREEN:
                            begin
                                green_next = chunk_byte;
                                phase_next = PH_BLUE;
                            end
                            PH_BLUE:
                            begin
                                blue_next  = chunk_byte;
                                phase_next = PH_CMD;
                                state_next = ST_LIT;
                            end
                            default:
                            begin
                                phase_next = PH_CMD;
                            end
                        endcase
                        if (bytes_dec == '0)
                        begin
                            phase_next = PH_CMD;
                        end
                    end
                end
            end

            ST_SNAP:
            begin
                if (sweep_reg < (IDX_W+1)'(PALETTE_ENTRIES))
                begin
                    ram_ctl.cur_re = 1'b1;
                    sw_wr_next     = 1'b1;
                    sw_addr_next   = sweep_reg[IDX_W-1:0];
                    sweep_next     = sweep_reg + (IDX_W+1)'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_COPY_RD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (pos_in && src_in)
                begin
                    ram_ctl.snap_re = 1'b1;
                    state_next      = ST_COPY_WR;
                end
                else
                begin
                    pos_next   = pos_sat;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_COPY_WR:
            begin
                if (push_ok)
                begin
                    ram_ctl.cur_we = 1'b1;
                    emit.push      = 1'b1;
                    emit.last      = (cnt_reg == CNT_W'(1))
                                  || (pos_reg == POS_W'(PALETTE_ENTRIES - 1))
                                  || (src_reg == SRC_W'(PALETTE_ENTRIES - 1));
                    pos_next       = pos_sat;
                    src_next       = src_reg + SRC_W'(1);
                    cnt_next       = cnt_reg - CNT_W'(1);
                    state_next     = ST_COPY_RD;
                end
            end

            ST_LIT:
            begin
                emit_rgb  = lit_rgb;
                cur_wdata = lit_rgb;
                if (!pos_in)
                begin
                    state_next = ST_IDLE;
                end
                else if (push_ok)
                begin
                    ram_ctl.cur_we = 1'b1;
                    emit.push      = 1'b1;
                    emit.last      = 1'b1;
                    pos_next       = pos_sat;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            phase_reg      <= PH_CMD;
            bytes_left_reg <= '0;
            pos_reg        <= '0;
            cnt_reg        <= '0;
            src_reg        <= '0;
            sweep_reg      <= '0;
            sw_wr_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            pos_reg        <= pos_next;
            cnt_reg        <= cnt_next;
            src_reg        <= src_next;
            sweep_reg      <= sweep_next;
            sw_wr_reg      <= sw_wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sw_addr_reg <= sw_addr_next;
        cmd_reg     <= cmd_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
    end

endmodule

>>> rtl/palette_delta_decoder.sv
// Output: each entry produced is registered and shows on entry_valid in the cycle after it is produced.
// Request bytes are taken only while idle: a skip or green byte keeps the decoder idle; a literal
// color writes and emits its entry after its last byte, waiting on output back-pressure; a copy
// does a snapshot read, then a current write, per entry written. A length byte first copies the
// current palette into the snapshot. Reset: both palettes are cleared to black by a pass over
// every entry; no request is taken until it completes.
module palette_delta_decoder import pdd_pkg::*; #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              chunk_valid,
    output logic              chunk_stall,
    input  logic [BYTE_W-1:0] chunk_byte,
    output logic              entry_valid,
    input  logic              entry_stall,
    output logic [BYTE_W-1:0] entry_index,
    output logic [BYTE_W-1:0] red,
    output logic [BYTE_W-1:0] green,
    output logic [BYTE_W-1:0] blue,
    output logic              last_of_run
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int POS_W = $clog2(PALETTE_ENTRIES + 1);

    emit_t             emit;
    ram_ctl_t          ram_ctl;
    logic [BYTE_W-1:0] emit_index;
    logic [RGB_W-1:0]  emit_rgb;
    logic              push_ok;
    logic [IDX_W-1:0]  cur_waddr, cur_raddr, snap_waddr, snap_raddr;
    logic [RGB_W-1:0]  cur_wdata, cur_rdata, snap_wdata, snap_rdata;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_index_reg;
    logic [RGB_W-1:0]  out_rgb_reg;
    logic              out_last_reg;

    assign push_ok = !out_valid_reg || !entry_stall;

    pdd_ctrl #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .IDX_W           (IDX_W),
        .POS_W           (POS_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk_valid (chunk_valid),
        .chunk_byte  (chunk_byte),
        .chunk_stall (chunk_stall),
        .push_ok     (push_ok),
        .emit        (emit),
        .emit_index  (emit_index),
        .emit_rgb    (emit_rgb),
        .ram_ctl     (ram_ctl),
        .cur_waddr   (cur_waddr),
        .cur_wdata   (cur_wdata),
        .cur_raddr   (cur_raddr),
        .cur_rdata   (cur_rdata),
        .snap_waddr  (snap_waddr),
        .snap_wdata  (snap_wdata),
        .snap_raddr  (snap_raddr),
        .snap_rdata  (snap_rdata)
    );

    pdd_ram #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (RGB_W)
    ) u_cur_ram (
        .clk   (clk),
        .we    (ram_ctl.cur_we),
        .waddr (cur_waddr),
        .wdata (cur_wdata),
        .re    (ram_ctl.cur_re),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    pdd_ram #(
        .DEPTH  (PALETTE_ENTRIES),
        .ADDR_W (IDX_W),
        .DATA_W (RGB_W)
    ) u_snap_ram (
        .clk   (clk),
        .we    (ram_ctl.snap_we),
        .waddr (snap_waddr),
        .wdata (snap_wdata),
        .re    (ram_ctl.snap_re),
        .raddr (snap_raddr),
        .rdata (snap_rdata)
    );

    always_comb
    begin
        if (emit.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!entry_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.push)
        begin
            out_index_reg <= emit_index;
            out_rgb_reg   <= emit_rgb;
            out_last_reg  <= emit.last;
        end
    end

    assign entry_valid = out_valid_reg;
    assign entry_index = out_index_reg;
    assign red         = out_rgb_reg[23:16];
    assign green       = out_rgb_reg[15:8];
    assign blue        = out_rgb_reg[7:0];
    assign last_of_run = out_last_reg;

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit.push |-> (!out_valid_reg || !entry_stall))
        else $error("result pushed into a full output register");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_valid |-> (entry_index < PALETTE_ENTRIES))
        else $error("entry index beyond palette");

    a_no_push_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit.push && ram_ctl.snap_we))
        else $error("result emitted during snapshot write");

    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        emit.push |-> chunk_stall)
        else $error("request taken while an entry is being produced");

endmodule

>>> tb/sv/palette_delta_decoder_tb.sv
`timescale 1ns / 1ps

module palette_delta_decoder_tb import pdd_pkg::*;;

    localparam int NUM_ENTRIES    = 256;
    localparam int ITEM_TARGET    = 460;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [BYTE_W-1:0] idx;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              last;
    } entry_rec_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              chunk_valid;
    logic              chunk_stall;
    logic [BYTE_W-1:0] chunk_byte;
    logic              entry_valid;
    logic              entry_stall;
    logic [BYTE_W-1:0] entry_index;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              last_of_run;

    // predicted palette state
    logic [RGB_W-1:0]  cur_pal [NUM_ENTRIES];
    logic [RGB_W-1:0]  snap_pal[NUM_ENTRIES];
    int                wr_pos;
    int                bytes_left;
    phase_t            parse_ph;
    logic [BYTE_W-1:0] pend_cmd;
    logic [BYTE_W-1:0] pend_green;

    entry_rec_t        pending_entries[$];
    int                errors     = 0;
    int                items_sent = 0;
    int                hold_req   = 0;
    bit                idle_on    = 1'b1;

    palette_delta_decoder #(
        .PALETTE_ENTRIES(NUM_ENTRIES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .chunk_valid(chunk_valid),
        .chunk_stall(chunk_stall),
        .chunk_byte (chunk_byte),
        .entry_valid(entry_valid),
        .entry_stall(entry_stall),
        .entry_index(entry_index),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last_of_run(last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [BYTE_W-1:0] widen6(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] s;
        s = v & VAL_MASK;
        return (s << 2) | (s >> 4);
    endfunction

    function automatic void bump_pos(input int n);
        wr_pos = (wr_pos + n > NUM_ENTRIES) ? NUM_ENTRIES : wr_pos + n;
    endfunction

    function automatic entry_rec_t make_rec(input int idx, input logic [RGB_W-1:0] rgb);
        entry_rec_t rec;
        rec.idx   = BYTE_W'(idx);
        rec.red   = rgb[23:16];
        rec.green = rgb[15:8];
        rec.blue  = rgb[7:0];
        rec.last  = 1'b0;
        return rec;
    endfunction

    task automatic apply_byte(input logic [BYTE_W-1:0] value);
        entry_rec_t       run_q[$];
        entry_rec_t       rec;
        logic [RGB_W-1:0] rgb;
        int               count;
        int               src;
        if (bytes_left == 0)
        begin
            snap_pal   = cur_pal;
            wr_pos     = 0;
            parse_ph   = PH_CMD;
            bytes_left = (value == 0) ? 0 : int'(value) * 4 - 1;
        end
        else
        begin
            bytes_left--;
            case (parse_ph)
                PH_CMD:
                begin
                    if ((value & SKIP_FLAG) != 0)
                        bump_pos(int'(value & SKIP_MASK) + 1);
                    else
                    begin
                        pend_cmd = value;
                        parse_ph = ((value & COPY_FLAG) != 0) ? PH_SRC : PH_GREEN;
                    end
                end
                PH_SRC:
                begin
                    count = int'(pend_cmd & VAL_MASK) + 1;
                    for (int k = 0; k < count; k++)
                    begin
                        src = int'(value) + k;
                        if (wr_pos < NUM_ENTRIES && src < NUM_ENTRIES)
                        begin
                            cur_pal[wr_pos] = snap_pal[src];
                            run_q.insert(run_q.size(), make_rec(wr_pos, cur_pal[wr_pos]));
                        end
                        bump_pos(1);
                    end
                    parse_ph = PH_CMD;
                end
                PH_GREEN:
                begin
                    pend_green = value;
                    parse_ph   = PH_BLUE;
                end
                default:
                begin
                    rgb = {widen6(pend_cmd), widen6(pend_green), widen6(value)};
                    if (wr_pos < NUM_ENTRIES)
                    begin
                        cur_pal[wr_pos] = rgb;
                        run_q.insert(run_q.size(), make_rec(wr_pos, rgb));
                    end
                    bump_pos(1);
                    parse_ph = PH_CMD;
                end
            endcase
            if (bytes_left == 0)
                parse_ph = PH_CMD;
            foreach (run_q[i])
            begin
                rec      = run_q[i];
                rec.last = (i == run_q.size() - 1);
                pending_entries.insert(pending_entries.size(), rec);
            end
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        bit taken;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            chunk_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chunk_valid <= 1'b1;
        chunk_byte  <= value;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !chunk_stall;
            @(posedge clk);
        end
        apply_byte(value);
        items_sent++;
    endtask

    task automatic wait_drained();
        chunk_valid <= 1'b0;
        @(posedge clk);
        while (pending_entries.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_entry();
        entry_rec_t want;
        if (pending_entries.size() == 0)
        begin
            $display("%0t: unexpected entry %0h expected none got rgb %0h%0h%0h",
                     $time, entry_index, red, green, blue);
            errors++;
        end
        else
        begin
            want = pending_entries.pop_front();
            check_field("entry_index", want.idx, entry_index);
            check_field("red", want.red, red);
            check_field("green", want.green, green);
            check_field("blue", want.blue, blue);
            check_field("last_of_run", {7'b0, want.last}, {7'b0, last_of_run});
        end
    endtask

    task automatic test_literal_colors();
        send_byte(8'h02);
        send_byte(8'h3F); send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'hC0); send_byte(8'h40);
        send_byte(SKIP_FLAG);
    endtask

    // skip to 128, copy 64, a copy whose source runs off the end, then a copy of 2
    task automatic test_skip_and_copy();
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h7F); send_byte(8'h00);
        send_byte(8'h7F); send_byte(8'hE0);
        send_byte(8'h41); send_byte(8'h10);
    endtask

    task automatic test_empty_and_truncated();
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h40); send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_end_of_palette();
        send_byte(8'h02);
        send_byte(8'hFF); send_byte(8'hFF);
        send_byte(8'h40); send_byte(8'h00);
        send_byte(8'h3F); send_byte(8'h3F); send_byte(8'h3F);
    endtask

    task automatic test_output_backpressure();
        idle_on  = 1'b0;
        hold_req = 600;
        send_byte(8'h02);
        repeat (3)
        begin
            send_byte(COPY_FLAG | VAL_MASK);
            send_byte(BYTE_W'($urandom_range(0, 192)));
        end
        send_byte(SKIP_FLAG);
        idle_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_chunks();
        logic [BYTE_W-1:0] body[$];
        int                units;
        int                kind;
        int                span;
        while (items_sent < ITEM_TARGET)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 19);
            if (kind == 0)
                send_byte(8'h00);
            else
            begin
                units = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                    : $urandom_range(1, 5);
                body.delete();
                while (body.size() < units * 4 - 1)
                begin
                    if (kind <= 2)
                        body.insert(body.size(), BYTE_W'($urandom_range(0, 255)));
                    else
                        case ($urandom_range(0, 9))
                            0, 1:
                            begin
                                span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                                   : $urandom_range(0, 7);
                                body.insert(body.size(), SKIP_FLAG | BYTE_W'(span));
                            end
                            2, 3, 4:
                            begin
                                span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                                   : $urandom_range(0, 7);
                                body.insert(body.size(), COPY_FLAG | BYTE_W'(span));
                                body.insert(body.size(), BYTE_W'($urandom_range(0, 255)));
                            end
                            default:
                            begin
                                body.insert(body.size(), BYTE_W'($urandom_range(0, 63)));
                                body.insert(body.size(), BYTE_W'($urandom_range(0, 255)));
                                body.insert(body.size(), BYTE_W'($urandom_range(0, 255)));
                            end
                        endcase
                end
                while (body.size() > units * 4 - 1)
                    void'(body.pop_back());
                send_byte(BYTE_W'(units));
                foreach (body[i])
                    send_byte(body[i]);
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin : result_side
        int stall_left;
        bit took;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            took = rst_n && entry_valid && !entry_stall;
            if (took)
                check_entry();
            @(posedge clk);
            if (took)
                stall_left = idle_on ? $urandom_range(0, 15) : 0;
            if (hold_req > 0)
            begin
                stall_left += hold_req;
                hold_req = 0;
            end
            if (stall_left > 0)
            begin
                entry_stall <= 1'b1;
                stall_left--;
            end
            else
                entry_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((chunk_valid && !chunk_stall) || (entry_valid && !entry_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("** palette_delta_decoder: FAILED **");
        $finish;
    end

    initial
    begin
        chunk_valid <= 1'b0;
        chunk_byte  <= '0;
        entry_stall <= 1'b0;
        rst_n       <= 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            cur_pal[i]  = '0;
            snap_pal[i] = '0;
        end
        wr_pos     = 0;
        bytes_left = 0;
        parse_ph   = PH_CMD;
        pend_cmd   = '0;
        pend_green = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_literal_colors();
        test_skip_and_copy();
        test_empty_and_truncated();
        test_end_of_palette();
        test_output_backpressure();
        test_random_chunks();

        wait_drained();
        repeat (NUM_ENTRIES + 16) @(posedge clk);
        errors += pending_entries.size();
        if (errors == 0)
            $display("** palette_delta_decoder: PASSED **");
        else
            $display("** palette_delta_decoder: FAILED **");
        $finish;
    end

endmodule
